### rtl/osine_pkg.sv
package osine_pkg;

    // Fixed field widths and formats
    localparam int ANGLE_BITS = 31;
    localparam int ANGLE_FRAC = 29;
    localparam int SINE_BITS  = 32;
    localparam int SINE_FRAC  = 30;
    localparam int COEF_BITS  = 50;
    localparam int NUM_COEFS  = 6;
    localparam int CFG_IDX_W  = 3;

    // Operand slice width of the partial-product multipliers
    localparam int MUL_CHUNK = 24;

    // Parameter defaults
    localparam int ANGLE_WIDTH_DEF        = 32;
    localparam int COEF_FRACTION_BITS_DEF = 48;

    typedef logic signed [COEF_BITS-1:0] coef_t;
    typedef coef_t coef_array_t [NUM_COEFS];

    // Register index of each coefficient
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_X3  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_X13 = 3'd5;

    // Minimax set, Q1.48, in register order x3 .. x13
    localparam coef_array_t COEF_RESET = '{
        -50'sd46912496117697,
        50'sd2345624801181,
        -50'sd55848198871,
        50'sd775657811,
        -50'sd7044883,
        50'sd43311
    };

    localparam logic signed [SINE_BITS-1:0] SINE_ONE = 32'sd1073741824;

endpackage

### rtl/osine_mulr.sv
module osine_mulr #(
    parameter int          A_W    = 31,
    parameter int          B_W    = 31,
    parameter int          SHIFT  = 26,
    parameter int          R_W    = 35,
    parameter logic [63:0] LIM    = 64'd17179869184,
    parameter int          SIDE_W = 31
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    in_valid,
    input  logic signed [A_W-1:0]   a,
    input  logic signed [B_W-1:0]   b,
    input  logic [SIDE_W-1:0]       side_in,
    output logic                    out_valid,
    output logic [R_W-1:0]          mag,
    output logic                    neg,
    output logic [SIDE_W-1:0]       side_out
);

    localparam int CH    = osine_pkg::MUL_CHUNK;
    localparam int NA    = (A_W + CH - 1) / CH;
    localparam int NB    = (B_W + CH - 1) / CH;
    localparam int AP_W  = NA * CH;
    localparam int BP_W  = NB * CH;
    localparam int P_W   = AP_W + BP_W;
    localparam int Q_W   = P_W + 1 - SHIFT;
    localparam int CMP_W = (Q_W > 64) ? Q_W : 64;
    localparam logic [P_W:0] RND = (P_W + 1)'(1) << (SHIFT - 1);

    // Stage 1: operand magnitudes and product sign
    logic                v0_reg;
    logic [A_W-1:0]      am_reg, am_next;
    logic [B_W-1:0]      bm_reg, bm_next;
    logic                neg0_reg;
    logic [SIDE_W-1:0]   side0_reg;

    // Stage 2: partial products
    logic                v1_reg;
    logic [2*CH-1:0]     pp_reg  [NA][NB];
    logic [2*CH-1:0]     pp_next [NA][NB];
    logic                neg1_reg;
    logic [SIDE_W-1:0]   side1_reg;

    // Stage 3: one row sum per slice of a
    logic                v2_reg;
    logic [P_W-1:0]      row_reg  [NA];
    logic [P_W-1:0]      row_next [NA];
    logic                neg2_reg;
    logic [SIDE_W-1:0]   side2_reg;

    // Stage 4: full product plus rounding constant
    logic                v3_reg;
    logic [P_W:0]        rsum_reg, rsum_next;
    logic                neg3_reg;
    logic [SIDE_W-1:0]   side3_reg;

    // Stage 5: shifted, saturated magnitude
    logic                v4_reg;
    logic [R_W-1:0]      mag_reg, mag_next;
    logic                neg4_reg;
    logic [SIDE_W-1:0]   side4_reg;

    logic [A_W-1:0]      a_u;
    logic [B_W-1:0]      b_u;
    logic [AP_W-1:0]     a_pad;
    logic [BP_W-1:0]     b_pad;
    logic [Q_W-1:0]      q;
    logic [CMP_W-1:0]    q_ext;

    assign a_u = a;
    assign b_u = b;

    // Take magnitudes of both operands
    always_comb
    begin
        am_next = a[A_W-1] ? (~a_u + A_W'(1)) : a_u;
        bm_next = b[B_W-1] ? (~b_u + B_W'(1)) : b_u;
    end

    // Multiply slice by slice
    assign a_pad = AP_W'(am_reg);
    assign b_pad = BP_W'(bm_reg);

    always_comb
    begin
        for (int i = 0; i < NA; i++)
        begin
            for (int j = 0; j < NB; j++)
            begin
                pp_next[i][j] = a_pad[i*CH +: CH] * b_pad[j*CH +: CH];
            end
        end
    end

    // Add the partial products of each row
    always_comb
    begin
        for (int i = 0; i < NA; i++)
        begin
            row_next[i] = '0;
            for (int j = 0; j < NB; j++)
            begin
                row_next[i] = row_next[i] + (P_W'(pp_reg[i][j]) << (j * CH));
            end
        end
    end

    // Add the rows and the half unit for rounding
    always_comb
    begin
        rsum_next = RND;
        for (int i = 0; i < NA; i++)
        begin
            rsum_next = rsum_next + ((P_W + 1)'(row_reg[i]) << (i * CH));
        end
    end

    // Drop the fraction bits and saturate
    assign q     = rsum_reg[P_W:SHIFT];
    assign q_ext = CMP_W'(q);

    always_comb
    begin
        if (q_ext > CMP_W'(LIM))
        begin
            mag_next = R_W'(LIM);
        end
        else
        begin
            mag_next = R_W'(q);
        end
    end

    // Advance the valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg <= in_valid;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // Advance the data
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            am_reg    <= am_next;
            bm_reg    <= bm_next;
            neg0_reg  <= a[A_W-1] ^ b[B_W-1];
            side0_reg <= side_in;

            pp_reg    <= pp_next;
            neg1_reg  <= neg0_reg;
            side1_reg <= side0_reg;

            row_reg   <= row_next;
            neg2_reg  <= neg1_reg;
            side2_reg <= side1_reg;

            rsum_reg  <= rsum_next;
            neg3_reg  <= neg2_reg;
            side3_reg <= side2_reg;

            mag_reg   <= mag_next;
            neg4_reg  <= neg3_reg;
            side4_reg <= side3_reg;
        end
    end

    assign out_valid = v4_reg;
    assign mag       = mag_reg;
    assign neg       = neg4_reg;
    assign side_out  = side4_reg;

    // Saturated magnitude never exceeds the limit
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (64'(mag) <= LIM))
        else $error("product magnitude above limit");

    // A held pipeline keeps its result
    assert property (@(posedge clk) disable iff (!rst_n)
        (!en && out_valid) |=> (out_valid && $stable(mag) && $stable(neg)))
        else $error("product changed while held");

endmodule

### rtl/osine_hstep.sv
module osine_hstep #(
    parameter int ANGLE_WIDTH        = osine_pkg::ANGLE_WIDTH_DEF,
    parameter int COEF_FRACTION_BITS = osine_pkg::COEF_FRACTION_BITS_DEF,
    parameter int IN_W               = osine_pkg::COEF_FRACTION_BITS_DEF + 3,
    parameter int ADD_W              = osine_pkg::COEF_BITS
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        en,
    input  logic                                        in_valid,
    input  logic signed [IN_W-1:0]                      acc_in,
    input  logic [ANGLE_WIDTH+2:0]                      x2_in,
    input  logic signed [osine_pkg::ANGLE_BITS-1:0]     x_in,
    input  logic signed [ADD_W-1:0]                     addend,
    output logic                                        out_valid,
    output logic signed [COEF_FRACTION_BITS+2:0]        acc_out,
    output logic [ANGLE_WIDTH+2:0]                      x2_out,
    output logic signed [osine_pkg::ANGLE_BITS-1:0]     x_out
);

    localparam int X2_W   = ANGLE_WIDTH + 3;
    localparam int ACC_W  = COEF_FRACTION_BITS + 3;
    localparam int M_W    = COEF_FRACTION_BITS + 2;
    localparam int AB     = osine_pkg::ANGLE_BITS;
    localparam int SIDE_W = AB + X2_W;
    localparam int SUM_W  = ((ADD_W > ACC_W) ? ADD_W : ACC_W) + 1;
    localparam logic [63:0] M_LIM = (64'd1 << M_W) - 64'd1;
    localparam logic signed [SUM_W-1:0] SUM_HI = {{(SUM_W - M_W){1'b0}}, {M_W{1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_LO = -SUM_HI;
    localparam logic signed [ACC_W-1:0] ACC_HI = {1'b0, {(ACC_W - 1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_LO = -ACC_HI;

    logic                    m_valid;
    logic [M_W-1:0]          m_mag;
    logic                    m_neg;
    logic [SIDE_W-1:0]       m_side;

    logic signed [SUM_W-1:0] add_ext;
    logic signed [SUM_W-1:0] mag_ext;
    logic signed [SUM_W-1:0] sum;

    logic                    v_reg;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic [X2_W-1:0]         x2_reg;
    logic signed [AB-1:0]    x_reg;

    // Rounded product acc * x2
    osine_mulr #(
        .A_W    (IN_W),
        .B_W    (X2_W + 1),
        .SHIFT  (ANGLE_WIDTH),
        .R_W    (M_W),
        .LIM    (M_LIM),
        .SIDE_W (SIDE_W)
    ) u_mul (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid),
        .a         (acc_in),
        .b         ($signed({1'b0, x2_in})),
        .side_in   ({x_in, x2_in}),
        .out_valid (m_valid),
        .mag       (m_mag),
        .neg       (m_neg),
        .side_out  (m_side)
    );

    // Add the addend (a coefficient, or the leading one) and clamp to just under four
    always_comb
    begin
        add_ext = SUM_W'(addend);
        mag_ext = SUM_W'($signed({1'b0, m_mag}));
        sum     = m_neg ? (add_ext - mag_ext) : (add_ext + mag_ext);
        if (sum > SUM_HI)
        begin
            acc_next = ACC_W'(SUM_HI);
        end
        else if (sum < SUM_LO)
        begin
            acc_next = ACC_W'(SUM_LO);
        end
        else
        begin
            acc_next = ACC_W'(sum);
        end
    end

    // Advance the valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg <= m_valid;
        end
    end

    // Advance the data
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            acc_reg <= acc_next;
            x2_reg  <= m_side[X2_W-1:0];
            x_reg   <= m_side[SIDE_W-1:X2_W];
        end
    end

    assign out_valid = v_reg;
    assign acc_out   = acc_reg;
    assign x2_out    = x2_reg;
    assign x_out     = x_reg;

    // Accumulator stays inside the clamp range
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((acc_out <= ACC_HI) && (acc_out >= ACC_LO)))
        else $error("accumulator outside clamp range");

endmodule

### rtl/odd_polynomial_sine.sv
// Pipeline: 47 register stages (x squared 5, six Horner steps 6 each, x*p 5, output 1).
// Throughput: one item per cycle; every multiply is split into 24-bit partial
//   products spread over five stages, and a stall holds the whole pipeline.
// Reset: asynchronous, active low; clears all valid bits and loads the minimax
//   coefficient set.
module odd_polynomial_sine #(
    parameter int ANGLE_WIDTH        = osine_pkg::ANGLE_WIDTH_DEF,
    parameter int COEF_FRACTION_BITS = osine_pkg::COEF_FRACTION_BITS_DEF
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        in_valid,
    output logic                                        in_stall,
    input  logic signed [osine_pkg::ANGLE_BITS-1:0]     angle,
    output logic                                        out_valid,
    input  logic                                        out_stall,
    output logic signed [osine_pkg::SINE_BITS-1:0]      sine,
    input  logic                                        cfg_we,
    input  logic [osine_pkg::CFG_IDX_W-1:0]             cfg_index,
    input  logic [osine_pkg::COEF_BITS-1:0]             cfg_data
);

    localparam int AB     = osine_pkg::ANGLE_BITS;
    localparam int NC     = osine_pkg::NUM_COEFS;
    localparam int X2_W   = ANGLE_WIDTH + 3;
    localparam int ACC_W  = COEF_FRACTION_BITS + 3;
    localparam int ADD_W  = (osine_pkg::COEF_BITS > COEF_FRACTION_BITS + 2) ?
                            osine_pkg::COEF_BITS : COEF_FRACTION_BITS + 2;
    localparam int SINE_W = osine_pkg::SINE_FRAC + 1;
    localparam int FIN_SIDE_W = AB + X2_W;

    localparam logic [63:0] X2_TOP   = 64'd1 << (ANGLE_WIDTH + 2);
    localparam logic [63:0] ACC_LIM2 = (64'd1 << (COEF_FRACTION_BITS + 3)) - 64'd2;
    localparam logic [63:0] X2_LIM   = (ACC_LIM2 < X2_TOP) ? ACC_LIM2 : X2_TOP;
    localparam logic [63:0] SINE_LIM = 64'd1 << osine_pkg::SINE_FRAC;
    localparam logic signed [ADD_W-1:0] P_ONE =
        {{(ADD_W - COEF_FRACTION_BITS - 1){1'b0}}, 1'b1, {COEF_FRACTION_BITS{1'b0}}};

    osine_pkg::coef_t coef_reg [NC];

    logic                    en;

    logic                    x2_valid;
    logic [X2_W-1:0]         x2_mag;
    logic                    x2_neg;
    logic [AB-1:0]           x2_side;

    logic                    v_chain   [NC+1];
    logic signed [ACC_W-1:0] acc_chain [NC+1];
    logic [X2_W-1:0]         x2_chain  [NC+1];
    logic signed [AB-1:0]    x_chain   [NC+1];
    logic signed [ADD_W-1:0] add_val   [NC];

    logic                    fin_valid;
    logic [SINE_W-1:0]       fin_mag;
    logic                    fin_neg;
    logic [FIN_SIDE_W-1:0]   fin_side;
    logic signed [AB-1:0]    fin_x;
    logic [X2_W-1:0]         fin_x2;

    logic                                   out_valid_reg;
    logic signed [osine_pkg::SINE_BITS-1:0] sine_reg, sine_next;

    // Move the whole pipeline unless a result waits on a stalled output
    assign en       = !out_valid_reg || !out_stall;
    assign in_stall = out_valid_reg && out_stall;

    // Coefficient registers; ignore indexes past the last one
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg <= osine_pkg::COEF_RESET;
        end
        else if (cfg_we && (cfg_index >= osine_pkg::CFG_COEF_X3)
                 && (cfg_index <= osine_pkg::CFG_COEF_X13))
        begin
            coef_reg[cfg_index] <= cfg_data;
        end
    end

    // Square the angle
    osine_mulr #(
        .A_W    (AB),
        .B_W    (AB),
        .SHIFT  (2 * osine_pkg::ANGLE_FRAC - ANGLE_WIDTH),
        .R_W    (X2_W),
        .LIM    (X2_LIM),
        .SIDE_W (AB)
    ) u_square (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid),
        .a         (angle),
        .b         (angle),
        .side_in   (angle),
        .out_valid (x2_valid),
        .mag       (x2_mag),
        .neg       (x2_neg),
        .side_out  (x2_side)
    );

    assign v_chain[0]   = x2_valid;
    assign acc_chain[0] = '0;
    assign x2_chain[0]  = x2_mag;
    assign x_chain[0]   = x2_side;

    // Addends: x11 down to x3, then the leading one
    genvar k;
    generate
        for (k = 0; k < NC; k++)
        begin : g_add
            if (k < NC - 1)
            begin : g_coef
                assign add_val[k] = ADD_W'(coef_reg[NC - 2 - k]);
            end
            else
            begin : g_one
                assign add_val[k] = P_ONE;
            end
        end
    endgenerate

    // First Horner step starts from the x13 coefficient
    osine_hstep #(
        .ANGLE_WIDTH        (ANGLE_WIDTH),
        .COEF_FRACTION_BITS (COEF_FRACTION_BITS),
        .IN_W               (osine_pkg::COEF_BITS),
        .ADD_W              (ADD_W)
    ) u_step0 (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v_chain[0]),
        .acc_in    (coef_reg[NC - 1]),
        .x2_in     (x2_chain[0]),
        .x_in      (x_chain[0]),
        .addend    (add_val[0]),
        .out_valid (v_chain[1]),
        .acc_out   (acc_chain[1]),
        .x2_out    (x2_chain[1]),
        .x_out     (x_chain[1])
    );

    // Remaining Horner steps
    generate
        for (k = 1; k < NC; k++)
        begin : g_step
            osine_hstep #(
                .ANGLE_WIDTH        (ANGLE_WIDTH),
                .COEF_FRACTION_BITS (COEF_FRACTION_BITS),
                .IN_W               (ACC_W),
                .ADD_W              (ADD_W)
            ) u_step (
                .clk       (clk),
                .rst_n     (rst_n),
                .en        (en),
                .in_valid  (v_chain[k]),
                .acc_in    (acc_chain[k]),
                .x2_in     (x2_chain[k]),
                .x_in      (x_chain[k]),
                .addend    (add_val[k]),
                .out_valid (v_chain[k+1]),
                .acc_out   (acc_chain[k+1]),
                .x2_out    (x2_chain[k+1]),
                .x_out     (x_chain[k+1])
            );
        end
    endgenerate

    // Scale the polynomial by the angle
    osine_mulr #(
        .A_W    (AB),
        .B_W    (ACC_W),
        .SHIFT  (osine_pkg::ANGLE_FRAC + COEF_FRACTION_BITS - osine_pkg::SINE_FRAC),
        .R_W    (SINE_W),
        .LIM    (SINE_LIM),
        .SIDE_W (FIN_SIDE_W)
    ) u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v_chain[NC]),
        .a         (x_chain[NC]),
        .b         (acc_chain[NC]),
        .side_in   ({x_chain[NC], x2_chain[NC]}),
        .out_valid (fin_valid),
        .mag       (fin_mag),
        .neg       (fin_neg),
        .side_out  (fin_side)
    );

    assign fin_x  = fin_side[FIN_SIDE_W-1:X2_W];
    assign fin_x2 = fin_side[X2_W-1:0];

    // Apply the sign
    always_comb
    begin
        sine_next = $signed(osine_pkg::SINE_BITS'(fin_mag));
        if (fin_neg)
        begin
            sine_next = -sine_next;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= fin_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sine_reg <= sine_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign sine      = sine_reg;

    // A square carries no sign
    assert property (@(posedge clk) disable iff (!rst_n)
        x2_valid |-> !x2_neg)
        else $error("negative square");

    // Zero angle travels with a zero square and gives a zero product
    assert property (@(posedge clk) disable iff (!rst_n)
        (fin_valid && (fin_x == '0)) |-> ((fin_x2 == '0) && (fin_mag == '0)))
        else $error("angle and square out of step");

    // Sine stays within plus or minus one
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((sine <= osine_pkg::SINE_ONE) && (sine >= -osine_pkg::SINE_ONE)))
        else $error("sine outside unit range");

endmodule

### test/tb_odd_polynomial_sine.sv
module tb_odd_polynomial_sine;
    timeunit 1ns;
    timeprecision 1ps;

    import osine_pkg::*;

    localparam int ANGLE_WIDTH   = ANGLE_WIDTH_DEF;
    localparam int COEF_FRAC     = COEF_FRACTION_BITS_DEF;
    localparam longint ACC_SAT   = (longint'(1) << (COEF_FRAC + 2)) - 1;
    localparam longint SINE_MAX  = longint'(1) << SINE_FRAC;
    localparam int HALF_PI       = 843314857;
    localparam int PIPE_DEPTH    = 47;
    localparam int HOLD_CYCLES   = 300;
    localparam int PHASES        = 6;
    localparam int PHASE_ITEMS   = 290;
    localparam int DIRECTED_ROWS = 27;
    localparam longint TIMEOUT_NS = 4_000_000;

    // Register indexes the block ignores
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    // Taylor set 1/3! .. 1/13! in Q1.48, alternating sign
    localparam coef_array_t TAYLOR_SET = '{
        -50'sd46912496118443,
        50'sd2345624805922,
        -50'sd55848209665,
        50'sd775669579,
        -50'sd7051542,
        50'sd45202
    };

    typedef enum logic [1:0] {ROW_ANGLE, ROW_WRITE, ROW_SET} row_kind_t;
    typedef enum logic [2:0] {
        SET_MINIMAX, SET_TAYLOR, SET_ZERO, SET_MAX, SET_MIN, SET_NEAR, SET_RANDOM
    } coef_set_t;

    typedef struct {
        row_kind_t                    kind;
        coef_set_t                    which;
        logic [CFG_IDX_W-1:0]         idx;
        logic [COEF_BITS-1:0]         data;
        logic signed [ANGLE_BITS-1:0] angle;
        bit                           known;
        logic signed [SINE_BITS-1:0]  sine;
    } stim_row_t;

    typedef struct {
        logic signed [ANGLE_BITS-1:0] angle;
        logic signed [SINE_BITS-1:0]  sine;
        bit                           known;
        logic signed [SINE_BITS-1:0]  typed;
    } sine_entry_t;

    logic                         clk = 1'b0;
    logic                         rst_n;
    logic                         in_valid;
    logic                         in_stall;
    logic signed [ANGLE_BITS-1:0] angle;
    logic                         out_valid;
    logic                         out_stall;
    logic signed [SINE_BITS-1:0]  sine;
    logic                         cfg_we;
    logic [CFG_IDX_W-1:0]         cfg_index;
    logic [COEF_BITS-1:0]         cfg_data;

    longint      coef_mirror [NUM_COEFS];
    sine_entry_t sine_expected [$];
    bit          pend_known;
    logic signed [SINE_BITS-1:0] pend_typed;
    bit          calm;
    bit          hold_req;
    int          gap_pct;
    int          stall_pct;
    int          error_count;
    int          items_accepted;
    int          sines_checked;
    int          settings_loaded;

    // Directed items; typed results only where they are plain to see
    stim_row_t directed_rows [DIRECTED_ROWS] = '{
        '{ROW_ANGLE, SET_MINIMAX, CFG_COEF_X3, '0, 31'sd0, 1'b1, 32'sd0},
        '{ROW_ANGLE, SET_MINIMAX, CFG_COEF_X3, '0, 31'sd1, 1'b0, 32'sd0},
        '{ROW_ANGLE, SET_MINIMAX, CFG_COEF_X3, '0, -31'sd1, 1'b0, 32'sd0},
        '{ROW_ANGLE, SET_MINIMAX, CFG_COEF_X3, '0, 31'sd843314857, 1'b0, 32'sd0},
        '{ROW_ANGLE, SET_MINIMAX, CFG_COEF_X3, '0, -31'sd843314857, 1'b0, 32'sd0},
        '{ROW_ANGLE, SET_MINIMAX, CFG_COEF_X3, '0, 31'sd421657428, 1'b0, 32'sd0},
        '{ROW_ANGLE, SET_MINIMAX, CFG_COEF_X3, '0, 31'sd1073741823, 1'b0, 32'sd0},
        '{ROW_ANGLE, SET_MINIMAX, CFG_COEF_X3, '0, 31'h4000_0000, 1'b0, 32'sd0},
        '{ROW_WRITE, SET_MINIMAX, CFG_SPARE_LO, {COEF_BITS{1'b1}}, 31'sd0, 1'b0, 32'sd0},
        '{ROW_WRITE, SET_MINIMAX, CFG_SPARE_HI, 50'h2_AAAA_AAAA_AAAA, 31'sd0, 1'b0, 32'sd0},
        '{ROW_ANGLE, SET_MINIMAX, CFG_COEF_X3, '0, 31'sd843314857, 1'b0, 32'sd0},
        '{ROW_SET, SET_ZERO, CFG_COEF_X3, '0, 31'sd0, 1'b0, 32'sd0},
        '{ROW_ANGLE, SET_ZERO, CFG_COEF_X3, '0, 31'sd0, 1'b1, 32'sd0},
        '{ROW_ANGLE, SET_ZERO, CFG_COEF_X3, '0, 31'sd1, 1'b1, 32'sd2},
        '{ROW_ANGLE, SET_ZERO, CFG_COEF_X3, '0, -31'sd1, 1'b1, -32'sd2},
        '{ROW_ANGLE, SET_ZERO, CFG_COEF_X3, '0, 31'sd536870911, 1'b1, 32'sd1073741822},
        '{ROW_ANGLE, SET_ZERO, CFG_COEF_X3, '0, 31'sd536870912, 1'b1, SINE_ONE},
        '{ROW_ANGLE, SET_ZERO, CFG_COEF_X3, '0, 31'sd1073741823, 1'b1, SINE_ONE},
        '{ROW_ANGLE, SET_ZERO, CFG_COEF_X3, '0, -31'sd536870913, 1'b1, -SINE_ONE},
        '{ROW_SET, SET_TAYLOR, CFG_COEF_X3, '0, 31'sd0, 1'b0, 32'sd0},
        '{ROW_ANGLE, SET_TAYLOR, CFG_COEF_X3, '0, 31'sd843314857, 1'b0, 32'sd0},
        '{ROW_ANGLE, SET_TAYLOR, CFG_COEF_X3, '0, -31'sd843314857, 1'b0, 32'sd0},
        '{ROW_ANGLE, SET_TAYLOR, CFG_COEF_X3, '0, 31'sd300000000, 1'b0, 32'sd0},
        '{ROW_SET, SET_MAX, CFG_COEF_X3, '0, 31'sd0, 1'b0, 32'sd0},
        '{ROW_ANGLE, SET_MAX, CFG_COEF_X3, '0, 31'sd1073741823, 1'b1, SINE_ONE},
        '{ROW_ANGLE, SET_MAX, CFG_COEF_X3, '0, 31'h4000_0000, 1'b1, -SINE_ONE},
        '{ROW_ANGLE, SET_MAX, CFG_COEF_X3, '0, 31'sd12345, 1'b0, 32'sd0}
    };

    coef_set_t phase_sets [PHASES] = '{
        SET_MINIMAX, SET_TAYLOR, SET_NEAR, SET_MIN, SET_RANDOM, SET_NEAR
    };

    odd_polynomial_sine DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .angle     (angle),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sine      (sine),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    // Product of magnitudes, rounded half away from zero, capped at lim
    function automatic longint round_mul(longint a, longint b, int sh, longint lim);
        logic [127:0] ma;
        logic [127:0] mb;
        logic [127:0] prod;
        bit           neg;
        neg  = (a < 0) != (b < 0);
        ma   = (a < 0) ? -a : a;
        mb   = (b < 0) ? -b : b;
        prod = (ma * mb + (128'd1 << (sh - 1))) >> sh;
        if (prod > 128'(lim))
            prod = 128'(lim);
        return neg ? -longint'(prod[63:0]) : longint'(prod[63:0]);
    endfunction

    function automatic longint clamp_mag(longint v, longint lim);
        if (v > lim)
            return lim;
        if (v < -lim)
            return -lim;
        return v;
    endfunction

    // Horner chain in x squared, then scale by x
    function automatic logic signed [SINE_BITS-1:0] sine_poly(
        logic signed [ANGLE_BITS-1:0] a
    );
        longint x;
        longint x2;
        longint acc;
        longint p;
        longint s;
        x   = a;
        x2  = round_mul(x, x, 2 * ANGLE_FRAC - ANGLE_WIDTH, ACC_SAT <<< 1);
        acc = coef_mirror[NUM_COEFS - 1];
        for (int i = NUM_COEFS - 2; i >= 0; i--)
        begin
            acc = clamp_mag(round_mul(acc, x2, ANGLE_WIDTH, ACC_SAT) + coef_mirror[i],
                            ACC_SAT);
        end
        p = clamp_mag(round_mul(acc, x2, ANGLE_WIDTH, ACC_SAT) + (longint'(1) << COEF_FRAC),
                      ACC_SAT);
        s = round_mul(x, p, ANGLE_FRAC + COEF_FRAC - SINE_FRAC, SINE_MAX);
        return s[SINE_BITS-1:0];
    endfunction

    function automatic coef_array_t coef_set(coef_set_t which);
        coef_array_t c;
        logic [63:0] r;
        for (int i = 0; i < NUM_COEFS; i++)
        begin
            r = {$urandom(), $urandom()};
            case (which)
                SET_MINIMAX: c[i] = COEF_RESET[i];
                SET_TAYLOR:  c[i] = TAYLOR_SET[i];
                SET_ZERO:    c[i] = '0;
                SET_MAX:     c[i] = {1'b0, {(COEF_BITS - 1){1'b1}}};
                SET_MIN:     c[i] = {1'b1, {(COEF_BITS - 1){1'b0}}};
                SET_NEAR:    c[i] = COEF_RESET[i] + coef_t'($signed(r[15:0]));
                default:     c[i] = r[COEF_BITS-1:0];
            endcase
        end
        return c;
    endfunction

    task automatic report_mismatch(string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        error_count++;
    endtask

    // Track accepted angles and check every sine taken from the block
    always @(posedge clk)
    begin : watch
        sine_entry_t e;
        sine_entry_t got;
        if (rst_n && in_valid && !in_stall)
        begin
            e.angle = angle;
            e.sine  = sine_poly(angle);
            e.known = pend_known;
            e.typed = pend_typed;
            sine_expected.push_back(e);
            items_accepted++;
        end
        if (rst_n && out_valid && !out_stall)
        begin
            if (sine_expected.size() == 0)
                report_mismatch($sformatf("sine %0d with no angle pending", sine));
            else
            begin
                got = sine_expected.pop_front();
                sines_checked++;
                if (sine !== got.sine)
                    report_mismatch($sformatf("angle %0d: sine %0d, predicted %0d",
                                              got.angle, sine, got.sine));
                if (got.known && sine !== got.typed)
                    report_mismatch($sformatf("angle %0d: sine %0d, table says %0d",
                                              got.angle, sine, got.typed));
            end
        end
    end

    // Offer one angle and hold it until the block takes it
    task automatic send_angle(logic signed [ANGLE_BITS-1:0] a, bit known,
                              logic signed [SINE_BITS-1:0] typed);
        angle      <= a;
        in_valid   <= 1'b1;
        pend_known = known;
        pend_typed = typed;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic maybe_gap();
        if (!calm && $urandom_range(0, 99) < gap_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge clk);
        end
    endtask

    // Drop valid and wait until every pending sine has come back
    task automatic settle();
        in_valid <= 1'b0;
        while (sine_expected.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Leaves the write enable high; the caller drops it
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [COEF_BITS-1:0] data);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_we    <= 1'b1;
        if (idx <= CFG_COEF_X13)
            coef_mirror[idx] = $signed(data);
        @(negedge clk);
    endtask

    task automatic load_set(coef_set_t which);
        coef_array_t c;
        c = coef_set(which);
        for (int i = 0; i < NUM_COEFS; i++)
            write_reg(CFG_IDX_W'(CFG_COEF_X3 + i), c[i]);
        cfg_we <= 1'b0;
        settings_loaded++;
    endtask

    // Receiver: random stall bursts, one long hold-off on request
    initial
    begin : receiver
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                out_stall <= 1'b0;
                hold_req = 1'b0;
            end
            else if (!calm && $urandom_range(0, 99) < stall_pct)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 19)) @(negedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    initial
    begin : sender
        logic signed [ANGLE_BITS-1:0] a;
        int                           v;
        int                           k;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        angle     = '0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        gap_pct   = 20;
        stall_pct = 20;
        calm      = 1'b0;
        hold_req  = 1'b0;
        for (int i = 0; i < NUM_COEFS; i++)
            coef_mirror[i] = COEF_RESET[i];
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        settings_loaded = 1;

        // Directed table
        foreach (directed_rows[r])
        begin
            case (directed_rows[r].kind)
                ROW_ANGLE:
                begin
                    send_angle(directed_rows[r].angle, directed_rows[r].known,
                               directed_rows[r].sine);
                    maybe_gap();
                end
                ROW_WRITE:
                begin
                    settle();
                    write_reg(directed_rows[r].idx, directed_rows[r].data);
                    cfg_we <= 1'b0;
                end
                default:
                begin
                    settle();
                    load_set(directed_rows[r].which);
                end
            endcase
        end

        // Random phases, one coefficient setting each
        for (int ph = 0; ph < PHASES; ph++)
        begin
            settle();
            load_set(phase_sets[ph]);
            calm = (ph == PHASES - 1);
            case ($urandom_range(0, 2))
                0: gap_pct = 0;
                1: gap_pct = 10;
                default: gap_pct = 45;
            endcase
            case ($urandom_range(0, 2))
                0: stall_pct = 0;
                1: stall_pct = 10;
                default: stall_pct = 45;
            endcase
            if (ph == 1)
                hold_req = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                k = $urandom_range(0, 99);
                if (k < 65)
                begin
                    v = int'($urandom_range(0, 2 * HALF_PI)) - HALF_PI;
                    a = v[ANGLE_BITS-1:0];
                end
                else if (k < 85)
                    a = ANGLE_BITS'($urandom());
                else
                begin
                    case ($urandom_range(0, 5))
                        0: v = HALF_PI;
                        1: v = -HALF_PI;
                        2: v = 1073741823;
                        3: v = -1073741824;
                        4: v = HALF_PI + int'($urandom_range(0, 255)) - 128;
                        default: v = int'($urandom_range(0, 511)) - 256;
                    endcase
                    a = v[ANGLE_BITS-1:0];
                end
                send_angle(a, 1'b0, '0);
                maybe_gap();
            end
        end

        // Drain, then watch for stray sines
        in_valid <= 1'b0;
        while (sine_expected.size() != 0)
            @(posedge clk);
        repeat (PIPE_DEPTH + 13) @(posedge clk);

        $display("%0d angles taken, %0d sines checked against the Horner predictor",
                 items_accepted, sines_checked);
        $display("%0d coefficient settings, including zero, Taylor and both extremes",
                 settings_loaded);
        if (error_count == 0)
            $display("tb_odd_polynomial_sine passed");
        else
            $display("tb_odd_polynomial_sine failed");
        $finish;
    end

    initial
    begin : watchdog
        #(TIMEOUT_NS);
        $display("tb_odd_polynomial_sine failed");
        $finish;
    end

endmodule

### sim.f
rtl/osine_pkg.sv
rtl/osine_mulr.sv
rtl/osine_hstep.sv
rtl/odd_polynomial_sine.sv
test/tb_odd_polynomial_sine.sv
